// ===== rtl/slac_pkg.sv =====
// Package with shared types and constants for the status LED activity controller.
`default_nettype none
package slac_pkg;

    localparam int unsigned HOLD_W = 8;
    localparam logic [HOLD_W-1:0] BLINK_TICKS_RESET = 8'd10;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_LINK   = 3'd1,
        OP_ADDR   = 3'd2,
        OP_NET    = 3'd3,
        OP_SERIAL = 3'd4,
        OP_ERROR  = 3'd5
    } opcode_t;

    // One registered event on its way from the input stage to the update logic.
    typedef struct packed {
        logic [2:0] opcode;
        logic       new_state;
    } event_t;

    // The three active-low pin levels.
    typedef struct packed {
        logic serial_pin;
        logic net_pin;
        logic error_pin;
    } pins_t;

endpackage
`default_nettype wire

// ===== rtl/slac_input_reg.sv =====
// Input register stage holding one event transaction.
`default_nettype none
module slac_input_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [2:0]       opcode,
    input  wire logic             new_state,
    input  wire logic             advance,
    output logic                  evt_valid,
    output slac_pkg::event_t      evt
);

    logic             valid_reg;
    logic             valid_next;
    slac_pkg::event_t evt_reg;
    logic             load;

    // The stage can take a new transaction when it is empty or its event moves on.
    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            evt_reg.opcode    <= opcode;
            evt_reg.new_state <= new_state;
        end
    end

    assign evt_valid = valid_reg;
    assign evt       = evt_reg;

endmodule
`default_nettype wire

// ===== rtl/slac_led_state.sv =====
// LED state registers, hold counters and the per-event update logic.
`default_nettype none
module slac_led_state (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write_en,
    input  wire logic [slac_pkg::HOLD_W-1:0] cfg_write_data,
    input  wire logic                        advance,
    input  wire slac_pkg::event_t            evt,
    output slac_pkg::pins_t                  pins_next
);

    logic [slac_pkg::HOLD_W-1:0] blink_ticks_reg;
    logic [slac_pkg::HOLD_W-1:0] serial_hold_reg, serial_hold_next;
    logic [slac_pkg::HOLD_W-1:0] net_hold_reg, net_hold_next;
    logic [slac_pkg::HOLD_W-1:0] error_hold_reg, error_hold_next;
    logic                        link_down_reg, link_down_next;
    logic                        address_ready_reg, address_ready_next;
    slac_pkg::pins_t             pins_reg;
    slac_pkg::pins_t             pins_upd;
    slac_pkg::opcode_t           op;

    assign op = slac_pkg::opcode_t'(evt.opcode);

    always_comb
    begin
        serial_hold_next   = serial_hold_reg;
        net_hold_next      = net_hold_reg;
        error_hold_next    = error_hold_reg;
        link_down_next     = link_down_reg;
        address_ready_next = address_ready_reg;
        pins_upd           = pins_reg;
        unique case (op)
            slac_pkg::OP_TICK:
            begin
                if (serial_hold_reg == '0)
                begin
                    pins_upd.serial_pin = 1'b1;
                end
                else
                begin
                    serial_hold_next = serial_hold_reg - 1'b1;
                end
                if (link_down_reg)
                begin
                    // No link: network dark, error lit, other counters frozen.
                    pins_upd.net_pin   = 1'b1;
                    pins_upd.error_pin = 1'b0;
                end
                else
                begin
                    if (net_hold_reg == '0)
                    begin
                        pins_upd.net_pin = !address_ready_reg;
                    end
                    else
                    begin
                        net_hold_next = net_hold_reg - 1'b1;
                    end
                    if (error_hold_reg == '0)
                    begin
                        pins_upd.error_pin = 1'b1;
                    end
                    else
                    begin
                        // An error indication blanks the other two LEDs.
                        error_hold_next     = error_hold_reg - 1'b1;
                        pins_upd.serial_pin = 1'b1;
                        pins_upd.net_pin    = 1'b1;
                    end
                end
            end
            slac_pkg::OP_LINK:
            begin
                link_down_next = !evt.new_state;
            end
            slac_pkg::OP_ADDR:
            begin
                address_ready_next = evt.new_state;
            end
            slac_pkg::OP_NET:
            begin
                net_hold_next    = blink_ticks_reg;
                pins_upd.net_pin = !pins_reg.net_pin;
            end
            slac_pkg::OP_SERIAL:
            begin
                serial_hold_next    = blink_ticks_reg;
                pins_upd.serial_pin = !pins_reg.serial_pin;
            end
            slac_pkg::OP_ERROR:
            begin
                error_hold_next     = blink_ticks_reg;
                pins_upd.error_pin  = 1'b0;
                pins_upd.serial_pin = 1'b1;
                pins_upd.net_pin    = 1'b1;
            end
            default:
            begin
                // Unused opcodes leave the state alone.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_ticks_reg   <= slac_pkg::BLINK_TICKS_RESET;
            serial_hold_reg   <= '0;
            net_hold_reg      <= '0;
            error_hold_reg    <= '0;
            link_down_reg     <= 1'b1;
            address_ready_reg <= 1'b0;
            pins_reg          <= '1;
        end
        else
        begin
            if (cfg_write_en)
            begin
                blink_ticks_reg <= cfg_write_data;
            end
            if (advance)
            begin
                serial_hold_reg   <= serial_hold_next;
                net_hold_reg      <= net_hold_next;
                error_hold_reg    <= error_hold_next;
                link_down_reg     <= link_down_next;
                address_ready_reg <= address_ready_next;
                pins_reg          <= pins_upd;
            end
        end
    end

    assign pins_next = pins_upd;

endmodule
`default_nettype wire

// ===== rtl/status_led_activity_controller_core.sv =====
// Top level of the status LED activity controller: input stage, update logic, result register.
// Path: an accepted event waits in the input register, then passes through the update logic into the result register.
// Throughput: one event per cycle while the output is not stalled; the input register, the state
// update and the result register each move one transaction per clock, so the input stalls only
// when a held result is stalled and the input register is full.
// Reset: asynchronous and active low; LED state all dark, link down, counters zero, blink_ticks 10.
`default_nettype none
module status_led_activity_controller_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_en,
    input  wire logic [7:0] cfg_write_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] opcode,
    input  wire logic       new_state,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            serial_led_pin,
    output logic            net_led_pin,
    output logic            error_led_pin
);

    logic             evt_valid;
    slac_pkg::event_t evt;
    slac_pkg::pins_t  pins_next;
    slac_pkg::pins_t  pins_out_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             advance;

    // An event is applied to the state in the same cycle it moves into the result
    // register, which happens whenever that register is empty or being drained.
    // This keeps state updates in exact transaction order and one per result.
    assign advance        = evt_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    slac_input_reg u_input_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .new_state (new_state),
        .advance   (advance),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    // The configuration register lives with the counters it reloads. The user must write it only
    // while no transaction is in flight; the block itself does not enforce this.
    slac_led_state u_led_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .advance        (advance),
        .evt            (evt),
        .pins_next      (pins_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The result register holds the pin levels reported for each event.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pins_out_reg <= pins_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign serial_led_pin = pins_out_reg.serial_pin;
    assign net_led_pin    = pins_out_reg.net_pin;
    assign error_led_pin  = pins_out_reg.error_pin;

endmodule
`default_nettype wire

// ===== dv/status_led_activity_controller_core_tb.sv =====
// Self-checking testbench for the status LED activity controller core.
`timescale 1ns / 1ps

module status_led_activity_controller_core_tb;

    // Opcodes 6 and 7 are not decoded by the block; it must report the pins unchanged.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // This bound leaves ample margin over the roughly 1800 events sent, even at the slowest pacing.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SEGMENTS = 8;
    localparam int unsigned EVENTS_PER_SEGMENT = 220;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write_en = 1'b0;
    logic [7:0] cfg_write_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] opcode = '0;
    logic       new_state = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       serial_led_pin;
    logic       net_led_pin;
    logic       error_led_pin;

    status_led_activity_controller_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .new_state      (new_state),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .serial_led_pin (serial_led_pin),
        .net_led_pin    (net_led_pin),
        .error_led_pin  (error_led_pin)
    );

    // Events waiting to be offered to the block, and pin levels waiting to be seen.
    slac_pkg::event_t pending_events[$];
    slac_pkg::pins_t  expected_pins[$];
    slac_pkg::event_t next_event;

    // Handshake pacing, in percent of cycles, changed from one segment to the next.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // Bookkeeping for the drain points and the end-of-run summary.
    int unsigned events_loaded = 0;
    int unsigned events_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned settings_used = 0;
    logic        in_taken = 1'b0;

    // Shadow of the LED controller state. It is updated once per accepted transaction.
    logic [7:0]      blink_setting;
    logic [7:0]      serial_timer;
    logic [7:0]      net_timer;
    logic [7:0]      error_timer;
    logic            link_is_down;
    logic            addr_is_ready;
    slac_pkg::pins_t led_levels;

    initial begin
        forever #5 clk = ~clk;
    end

    // Reset is held low at the start and never asserted again. The shadow state is
    // cleared here as well, so it matches the block's reset values.
    initial begin
        blink_setting = slac_pkg::BLINK_TICKS_RESET;
        serial_timer  = '0;
        net_timer     = '0;
        error_timer   = '0;
        link_is_down  = 1'b1;
        addr_is_ready = 1'b0;
        led_levels    = '{serial_pin: 1'b1, net_pin: 1'b1, error_pin: 1'b1};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Applies one event to the shadow state and returns the three pin levels that the
    // block must report for it. Every event, including an ignored one, yields one result.
    function automatic slac_pkg::pins_t apply_led_event(slac_pkg::event_t ev);
        case (ev.opcode)
            slac_pkg::OP_TICK: begin
                // The serial timer always runs, whatever the link does.
                if (serial_timer == 0)
                    led_levels.serial_pin = 1'b1;
                else
                    serial_timer = serial_timer - 8'd1;
                if (link_is_down) begin
                    // With the link down the other two timers are frozen.
                    led_levels.net_pin   = 1'b1;
                    led_levels.error_pin = 1'b0;
                end
                else begin
                    if (net_timer == 0)
                        led_levels.net_pin = ~addr_is_ready;
                    else
                        net_timer = net_timer - 8'd1;
                    // A running error indication keeps the other two LEDs blanked.
                    if (error_timer == 0)
                        led_levels.error_pin = 1'b1;
                    else begin
                        error_timer = error_timer - 8'd1;
                        led_levels.serial_pin = 1'b1;
                        led_levels.net_pin    = 1'b1;
                    end
                end
            end
            slac_pkg::OP_LINK: link_is_down = ~ev.new_state;
            slac_pkg::OP_ADDR: addr_is_ready = ev.new_state;
            slac_pkg::OP_NET: begin
                net_timer = blink_setting;
                led_levels.net_pin = ~led_levels.net_pin;
            end
            slac_pkg::OP_SERIAL: begin
                serial_timer = blink_setting;
                led_levels.serial_pin = ~led_levels.serial_pin;
            end
            slac_pkg::OP_ERROR: begin
                error_timer = blink_setting;
                led_levels.error_pin  = 1'b0;
                led_levels.serial_pin = 1'b1;
                led_levels.net_pin    = 1'b1;
            end
            default: ;
        endcase
        return led_levels;
    endfunction

    // Random event mix: half timebase ticks so that the timers actually expire, the
    // link kept up most of the time so the net and error paths are exercised, and a
    // small share of undecoded opcodes as noise.
    function automatic slac_pkg::event_t random_led_event();
        slac_pkg::event_t ev;
        int unsigned      roll;
        roll = $urandom_range(99);
        ev.new_state = 1'($urandom_range(1));
        if (roll < 50)
            ev.opcode = slac_pkg::OP_TICK;
        else if (roll < 58) begin
            ev.opcode = slac_pkg::OP_LINK;
            ev.new_state = ($urandom_range(9) != 0);
        end
        else if (roll < 65)
            ev.opcode = slac_pkg::OP_ADDR;
        else if (roll < 76)
            ev.opcode = slac_pkg::OP_NET;
        else if (roll < 87)
            ev.opcode = slac_pkg::OP_SERIAL;
        else if (roll < 97)
            ev.opcode = slac_pkg::OP_ERROR;
        else
            ev.opcode = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
        return ev;
    endfunction

    task automatic queue_event(logic [2:0] op, logic level);
        pending_events.push_back('{opcode: op, new_state: level});
        events_loaded++;
    endtask

    // Blocks until every queued event has produced its result, then lets the pipeline
    // settle so that a register write cannot overlap a transaction.
    task automatic wait_until_drained();
        while (results_seen < events_loaded)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_blink_ticks(logic [7:0] value);
        wait_until_drained();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        blink_setting = value;
        settings_used++;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // Driver: a new event is presented only after the previous transaction was taken,
    // so a stalled payload never changes. Inputs move on the falling edge.
    always @(negedge clk) begin
        if (!in_valid || in_taken) begin
            if (rst_n && pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_event = pending_events.pop_front();
                opcode    <= next_event.opcode;
                new_state <= next_event.new_state;
                in_valid  <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: checks each result transaction against the oldest expectation, then
    // records any event transaction accepted at the same edge.
    always @(posedge clk) begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_pins.size() == 0) begin
                $error("result transaction with no event outstanding");
                mismatches++;
            end
            else begin
                if (serial_led_pin !== expected_pins[0].serial_pin) begin
                    $error("serial_led_pin: expected %0b, got %0b",
                           expected_pins[0].serial_pin, serial_led_pin);
                    mismatches++;
                end
                if (net_led_pin !== expected_pins[0].net_pin) begin
                    $error("net_led_pin: expected %0b, got %0b",
                           expected_pins[0].net_pin, net_led_pin);
                    mismatches++;
                end
                if (error_led_pin !== expected_pins[0].error_pin) begin
                    $error("error_led_pin: expected %0b, got %0b",
                           expected_pins[0].error_pin, error_led_pin);
                    mismatches++;
                end
                void'(expected_pins.pop_front());
            end
        end
        if (rst_n && in_valid && !in_stall) begin
            expected_pins.push_back(apply_led_event('{opcode: opcode, new_state: new_state}));
            events_sent++;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] blink_choice [SEGMENTS];
        blink_choice = '{8'd255, 8'd0, 8'd3, 8'd1, 8'd128, 8'd5, 8'd2, 8'd10};
        // Two of the settings are drawn at random.
        blink_choice[4] = 8'($urandom_range(20, 254));
        blink_choice[6] = 8'($urandom_range(1, 15));

        @(posedge rst_n);
        @(negedge clk);

        // Directed part at the reset blink setting. With the link down a tick lights the
        // error LED and darkens the net LED; undecoded opcodes leave the pins alone;
        // link and address changes only take effect on the next tick.
        queue_event(slac_pkg::OP_TICK, 1'b0);
        queue_event(OP_SPARE_LO, 1'b1);
        queue_event(OP_SPARE_HI, 1'b0);
        queue_event(slac_pkg::OP_SERIAL, 1'b0);
        queue_event(slac_pkg::OP_NET, 1'b1);
        queue_event(slac_pkg::OP_ERROR, 1'b0);
        queue_event(slac_pkg::OP_TICK, 1'b1);
        queue_event(slac_pkg::OP_LINK, 1'b1);
        queue_event(slac_pkg::OP_ADDR, 1'b1);
        queue_event(slac_pkg::OP_TICK, 1'b0);
        queue_event(slac_pkg::OP_TICK, 1'b0);

        // A zero blink setting: the next tick restores the idle level at once.
        write_blink_ticks(8'd0);
        queue_event(slac_pkg::OP_SERIAL, 1'b1);
        queue_event(slac_pkg::OP_TICK, 1'b0);
        queue_event(slac_pkg::OP_NET, 1'b0);
        queue_event(slac_pkg::OP_ERROR, 1'b1);
        queue_event(slac_pkg::OP_TICK, 1'b0);
        queue_event(slac_pkg::OP_TICK, 1'b0);
        queue_event(slac_pkg::OP_ADDR, 1'b0);
        queue_event(slac_pkg::OP_TICK, 1'b1);
        queue_event(slac_pkg::OP_LINK, 1'b0);
        queue_event(slac_pkg::OP_TICK, 1'b0);
        queue_event(slac_pkg::OP_LINK, 1'b1);

        // Random segments. Each one drains completely before the next register write,
        // so the sender pauses until every expected result has come. The idling mode
        // cycles through none, sender only, receiver only and light on both sides.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            write_blink_ticks(blink_choice[seg]);
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            for (int n = 0; n < EVENTS_PER_SEGMENT; n++)
                pending_events.push_back(random_led_event());
            events_loaded += EVENTS_PER_SEGMENT;
        end

        wait_until_drained();
        repeat (10) @(negedge clk);

        $display("Sent %0d events and checked %0d pin results under %0d blink settings,",
                 events_sent, results_seen, settings_used + 1);
        $display("with no idling, sender gaps, receiver stalls and mixed pacing.");
        if (mismatches == 0 && expected_pins.size() == 0 && results_seen == events_sent)
            $display("simulation ok");
        else begin
            if (expected_pins.size() != 0)
                $error("%0d expected results never arrived", expected_pins.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
